// ===== rtl/core/uart_addressed_pin_pulse_controller_defines.svh =====
// Assertion macros used by the checker file of the pin pulse controller.
`ifndef UART_ADDRESSED_PIN_PULSE_CONTROLLER_DEFINES_SVH
`define UART_ADDRESSED_PIN_PULSE_CONTROLLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UAPC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("uapc check failed");

// Consequent must hold in the cycle after the antecedent.
`define UAPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("uapc check failed");

`endif

// ===== rtl/core/uapc_pkg.sv =====
// Shared types and constants of the addressed pin pulse controller.
`default_nettype none

package uapc_pkg;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_TICKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TICKS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TENTH_TICKS    = 3'd4;

	// Register values after reset.
	localparam logic [7:0]  RST_OWN_ADDRESS    = 8'd2;
	localparam logic [15:0] RST_HALF_BIT_TICKS = 16'd416;
	localparam logic [15:0] RST_BIT_TICKS      = 16'd833;
	localparam logic [19:0] RST_BLOCK_TICKS    = 20'd30000;
	localparam logic [19:0] RST_TENTH_TICKS    = 20'd100000;

	// Duration byte that keeps a pin on without a timed pulse.
	localparam logic [7:0] DUR_FOREVER = 8'd255;

	// Stream word widths.
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 8;

	// Current register settings handed to the receive core.
	typedef struct packed {
		logic [7:0]  own_address;
		logic [15:0] half_bit_ticks;
		logic [15:0] bit_ticks;
		logic [19:0] block_ticks;
		logic [19:0] tenth_ticks;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/uapc_cfg_regs.sv =====
// Configuration register file of the addressed pin pulse controller.
`default_nettype none

module uapc_cfg_regs (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            wr_en,
	input  wire [uapc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire [uapc_pkg::CFG_DATA_W-1:0] wr_data,
	output uapc_pkg::cfg_t                 cfg
);
	import uapc_pkg::*;

	cfg_t cfg_q;

	// Write one register per word; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address    <= RST_OWN_ADDRESS;
			cfg_q.half_bit_ticks <= RST_HALF_BIT_TICKS;
			cfg_q.bit_ticks      <= RST_BIT_TICKS;
			cfg_q.block_ticks    <= RST_BLOCK_TICKS;
			cfg_q.tenth_ticks    <= RST_TENTH_TICKS;
		end else if (wr_en) begin
			case (wr_index)
				CFG_OWN_ADDRESS:    cfg_q.own_address    <= wr_data[7:0];
				CFG_HALF_BIT_TICKS: cfg_q.half_bit_ticks <= wr_data[15:0];
				CFG_BIT_TICKS:      cfg_q.bit_ticks      <= wr_data[15:0];
				CFG_BLOCK_TICKS:    cfg_q.block_ticks    <= wr_data;
				CFG_TENTH_TICKS:    cfg_q.tenth_ticks    <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/uapc_rx_core.sv =====
// Serial receiver, message decoder and pin pulse timer, one tick per step.
`default_nettype none

module uapc_rx_core #(
	parameter int PIN_COUNT = 5
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            step,
	input  wire            line,
	input  uapc_pkg::cfg_t cfg,
	output logic [4:0]     pin_levels,
	output logic           busy
);
	import uapc_pkg::*;

	// Receiver phase codes; the unused codes fall back to idle.
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_HALF  = 3'd1;
	localparam logic [2:0] PH_BITS  = 3'd2;
	localparam logic [2:0] PH_STOP  = 3'd3;
	localparam logic [2:0] PH_BLOCK = 3'd4;
	localparam logic [2:0] PH_PULSE = 3'd5;

	localparam logic [7:0] PIN_MAX = 8'(PIN_COUNT);

	logic [2:0]           phase_q, phase_d;
	logic                 prev_q;
	logic [19:0]          cnt_q, cnt_d;
	logic [3:0]           bidx_q, bidx_d;
	logic [7:0]           shift_q, shift_d;
	logic [1:0]           pos_q, pos_d;
	logic                 matched_q, matched_d;
	logic [7:0]           pin_num_q, pin_num_d;
	logic [7:0]           tenths_q, tenths_d;
	logic [PIN_COUNT-1:0] pins_q, pins_d;

	logic                 expire;
	logic [19:0]          cnt_dec;
	logic [19:0]          half_load, bit_load, tenth_load;
	logic [1:0]           pos_inc;
	logic [3:0]           bidx_inc;
	logic [7:0]           tenths_dec;
	logic                 pin_ok;
	logic [2:0]           pin_idx;
	logic [PIN_COUNT-1:0] pin_bit;
	logic [6:0]           pin_wide;

	// Countdown and reload values; a zero tick setting acts as one.
	assign expire     = (cnt_q <= 20'd1);
	assign cnt_dec    = expire ? 20'd0 : cnt_q - 20'd1;
	assign half_load  = (cfg.half_bit_ticks == 16'd0) ? 20'd1 : 20'(cfg.half_bit_ticks);
	assign bit_load   = (cfg.bit_ticks == 16'd0) ? 20'd1 : 20'(cfg.bit_ticks);
	assign tenth_load = (cfg.tenth_ticks == 20'd0) ? 20'd1 : cfg.tenth_ticks;
	assign pos_inc    = pos_q + 2'd1;
	assign bidx_inc   = bidx_q + 4'd1;
	assign tenths_dec = tenths_q - 8'd1;

	// Selected pin and its one-hot mask.
	assign pin_ok  = (pin_num_q >= 8'd1) && (pin_num_q <= PIN_MAX);
	assign pin_idx = pin_num_q[2:0] - 3'd1;
	assign pin_bit = PIN_COUNT'(1) << pin_idx;

	// Next state for one tick.
	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		bidx_d    = bidx_q;
		shift_d   = shift_q;
		pos_d     = pos_q;
		matched_d = matched_q;
		pin_num_d = pin_num_q;
		tenths_d  = tenths_q;
		pins_d    = pins_q;
		case (phase_q)
			PH_HALF: begin
				cnt_d = cnt_dec;
				if (expire) begin
					phase_d = PH_BITS;
					cnt_d   = bit_load;
				end
			end
			PH_BITS: begin
				cnt_d = cnt_dec;
				if (expire) begin
					if (bidx_q < 4'd8) begin
						shift_d[bidx_q[2:0]] = shift_q[bidx_q[2:0]] | line;
					end
					bidx_d = bidx_inc;
					cnt_d  = bit_load;
					if (bidx_inc >= 4'd8) begin
						phase_d = PH_STOP;
					end
				end
			end
			PH_STOP: begin
				cnt_d = cnt_dec;
				if (expire) begin
					// A whole byte is in: address, pin or duration by position.
					phase_d = PH_IDLE;
					pos_d   = pos_inc;
					if (pos_inc == 2'd1) begin
						if (shift_q == cfg.own_address) begin
							matched_d = 1'b1;
						end else begin
							matched_d = 1'b0;
							pos_d     = 2'd0;
							if (cfg.block_ticks != 20'd0) begin
								phase_d = PH_BLOCK;
								cnt_d   = cfg.block_ticks;
							end
						end
					end else if (pos_inc == 2'd2) begin
						if (matched_q) begin
							pin_num_d = shift_q;
						end
					end else begin
						if (matched_q && pin_ok) begin
							if (shift_q == 8'd0) begin
								pins_d = pins_q & ~pin_bit;
							end else begin
								pins_d = pins_q | pin_bit;
								if (shift_q != DUR_FOREVER) begin
									tenths_d = shift_q;
									cnt_d    = tenth_load;
									phase_d  = PH_PULSE;
								end
							end
						end
						pos_d     = 2'd0;
						matched_d = 1'b0;
					end
				end
			end
			PH_BLOCK: begin
				cnt_d = cnt_dec;
				if (expire) begin
					phase_d = PH_IDLE;
				end
			end
			PH_PULSE: begin
				cnt_d = cnt_dec;
				if (expire) begin
					tenths_d = tenths_dec;
					if (tenths_dec == 8'd0) begin
						if (pin_ok) begin
							pins_d = pins_q & ~pin_bit;
						end
						phase_d = PH_IDLE;
					end else begin
						cnt_d = tenth_load;
					end
				end
			end
			default: begin
				// Idle: a falling edge on the line starts a byte.
				phase_d = PH_IDLE;
				if (prev_q && !line) begin
					phase_d = PH_HALF;
					cnt_d   = half_load;
					bidx_d  = 4'd0;
					shift_d = 8'd0;
				end
			end
		endcase
	end

	// State registers; they also hold the result shown on the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			prev_q    <= 1'b1;
			cnt_q     <= 20'd0;
			bidx_q    <= 4'd0;
			shift_q   <= 8'd0;
			pos_q     <= 2'd0;
			matched_q <= 1'b0;
			pin_num_q <= 8'd0;
			tenths_q  <= 8'd0;
			pins_q    <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			prev_q    <= line;
			cnt_q     <= cnt_d;
			bidx_q    <= bidx_d;
			shift_q   <= shift_d;
			pos_q     <= pos_d;
			matched_q <= matched_d;
			pin_num_q <= pin_num_d;
			tenths_q  <= tenths_d;
			pins_q    <= pins_d;
		end
	end

	// Only the low five pins are visible.
	assign pin_wide   = 7'(pins_q);
	assign pin_levels = pin_wide[4:0];
	assign busy       = (phase_q != PH_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/uart_addressed_pin_pulse_controller.sv =====
// Top level of the addressed pin pulse controller with its 8N1 receiver.
// A tick word goes into the input register, then into the core state registers.
// Throughput: one tick word per cycle; the input register and the state register
// form a two-stage pipeline that advances whenever the result word is taken or empty.
// Reset: asynchronous, active low; clears the pipeline, receiver state and pins,
// and loads the register defaults. No clearing pass is needed.
`default_nettype none

module uart_addressed_pin_pulse_controller #(
	parameter int PIN_COUNT = 5
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire [uapc_pkg::IN_TDATA_W-1:0] s_tdata,   // [0] line_level, [7:1] zero
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [uapc_pkg::OUT_TDATA_W-1:0] m_tdata, // [4:0] pin_levels, [5] busy_res, [7:6] zero
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [uapc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [uapc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import uapc_pkg::*;

	cfg_t       cfg;
	logic       valid_s1;
	logic       line_s1;
	logic       out_valid_q;
	logic       advance;
	logic       step;
	logic [4:0] pin_levels;
	logic       busy;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	uapc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Pipeline control: the result stage frees up when empty or taken.
	assign advance  = !out_valid_q || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// Input register for the line sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			line_s1 <= s_tdata[0];
		end
	end

	// Result word valid flag; the word itself is the core's state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	uapc_rx_core #(
		.PIN_COUNT (PIN_COUNT)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.line       (line_s1),
		.cfg        (cfg),
		.pin_levels (pin_levels),
		.busy       (busy)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, busy, pin_levels};

endmodule

`default_nettype wire

// ===== rtl/core/uapc_checker.sv =====
// Port-level checker for the addressed pin pulse controller, with its bind.
`default_nettype none
`include "uart_addressed_pin_pulse_controller_defines.svh"

module uapc_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             s_tready,
	input wire                             m_tvalid,
	input wire                             m_tready,
	input wire [uapc_pkg::OUT_TDATA_W-1:0] m_tdata
);
	logic       have_prev_q;
	logic       prev_busy_q;
	logic [4:0] prev_pins_q;
	logic       out_take;

	assign out_take = m_tvalid && m_tready;

	// Remember the last result word delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
		end else if (out_take) begin
			have_prev_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			prev_busy_q <= m_tdata[5];
			prev_pins_q <= m_tdata[4:0];
		end
	end

	// A stalled result word holds.
	`UAPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// The input side only stalls while a result word is waiting.
	`UAPC_ASSERT_SAME(a_stall_needs_result, !s_tready, m_tvalid)

	// Pins change only at the end of a byte or pulse, so never right after an idle tick.
	`UAPC_ASSERT_SAME(a_idle_keeps_pins, out_take && have_prev_q && !prev_busy_q, m_tdata[4:0] == prev_pins_q)

	// The padding bits of a result word are zero.
	`UAPC_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[7:6] == 2'b00)

endmodule

bind uart_addressed_pin_pulse_controller uapc_checker u_uapc_checker (.*);

`default_nettype wire
